### rtl/csda_pkg.sv
// Shared types, constants and register map for the current sample alarm block.
`timescale 1ns / 1ps

package csda_pkg;

  // Converter sample width.
  localparam int SAMPLE_BITS = 10;

  localparam int ZP_W   = 10;
  localparam int DB_W   = 6;
  localparam int LIM_W  = 13;
  localparam int MAG_W  = 13;
  localparam int LVL_W  = 2;

  localparam int HIST_DEPTH = 3;
  localparam int SUM_W      = MAG_W + 2;

  // Signed compare width that holds sample, zero point and both band edges.
  localparam int CMP_W  = ((SAMPLE_BITS > ZP_W) ? SAMPLE_BITS : ZP_W) + 2;
  localparam int DIST_W = CMP_W - 1;
  localparam int PROD_W = DIST_W + 3;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  // floor(x / 3) == (x * DIV3_MUL) >> DIV3_SHIFT for every x below 2**DIV3_SHIFT.
  localparam int DIV3_SHIFT = SUM_W + 2;
  localparam int DIV3_MUL_I = ((1 << DIV3_SHIFT) + 1) / 3;
  localparam int DIV3_W     = SUM_W + DIV3_SHIFT;
  localparam logic [DIV3_W-1:0] DIV3_MUL = DIV3_W'(DIV3_MUL_I);

  // Configuration port.
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef enum logic [2:0] {
    REG_ZERO_POINT = 3'd0,
    REG_DEAD_BAND  = 3'd1,
    REG_LOW_LIMIT  = 3'd2,
    REG_MID_LIMIT  = 3'd3,
    REG_HIGH_LIMIT = 3'd4
  } reg_idx_t;

  localparam logic [ZP_W-1:0]  ZP_RST   = ZP_W'(512);
  localparam logic [DB_W-1:0]  DB_RST   = DB_W'(5);
  localparam logic [LIM_W-1:0] LOW_RST  = LIM_W'(1000);
  localparam logic [LIM_W-1:0] MID_RST  = LIM_W'(1500);
  localparam logic [LIM_W-1:0] HIGH_RST = LIM_W'(2000);

  localparam logic [LVL_W-1:0] LVL_NONE = 2'd0;
  localparam logic [LVL_W-1:0] LVL_LOW  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_MID  = 2'd2;
  localparam logic [LVL_W-1:0] LVL_HIGH = 2'd3;

  typedef struct packed {
    logic [ZP_W-1:0]  zero_point;
    logic [DB_W-1:0]  dead_band;
    logic [LIM_W-1:0] low_alarm_limit;
    logic [LIM_W-1:0] mid_alarm_limit;
    logic [LIM_W-1:0] high_alarm_limit;
  } cfg_t;

endpackage

### rtl/csda_regs.sv
// APB configuration registers for the current sample alarm block.
`timescale 1ns / 1ps

module csda_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csda_pkg::CFG_AW-1:0]   paddr,
  input  logic [csda_pkg::CFG_DW-1:0]   pwdata,
  output logic [csda_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output csda_pkg::cfg_t                cfg
);
  import csda_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_point       <= ZP_RST;
      cfg_r.dead_band        <= DB_RST;
      cfg_r.low_alarm_limit  <= LOW_RST;
      cfg_r.mid_alarm_limit  <= MID_RST;
      cfg_r.high_alarm_limit <= HIGH_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ZERO_POINT: cfg_r.zero_point       <= pwdata[ZP_W-1:0];
        REG_DEAD_BAND:  cfg_r.dead_band        <= pwdata[DB_W-1:0];
        REG_LOW_LIMIT:  cfg_r.low_alarm_limit  <= pwdata[LIM_W-1:0];
        REG_MID_LIMIT:  cfg_r.mid_alarm_limit  <= pwdata[LIM_W-1:0];
        REG_HIGH_LIMIT: cfg_r.high_alarm_limit <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ZERO_POINT: prdata = CFG_DW'(cfg_r.zero_point);
      REG_DEAD_BAND:  prdata = CFG_DW'(cfg_r.dead_band);
      REG_LOW_LIMIT:  prdata = CFG_DW'(cfg_r.low_alarm_limit);
      REG_MID_LIMIT:  prdata = CFG_DW'(cfg_r.mid_alarm_limit);
      REG_HIGH_LIMIT: prdata = CFG_DW'(cfg_r.high_alarm_limit);
      default:        prdata = '0;
    endcase
  end

endmodule

### rtl/current_sample_deadband_average_alarm.sv
// Top level: dead band, three-sample average and alarm classing of current samples.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | in_sample
//   out_    | output    | out_valid / out_stall| out_average_magnitude, out_alarm_level,
//           |           |                      | out_polarity_dot
//   cfg_    | input     | APB psel/penable     | five registers at byte address 4*i
//
// One sample per cycle while out_stall stays low; a result is registered in turn by the input
// register, the magnitude/history stage and the divide-by-3 and classing stage.
// Each stage holds while the one after it is full and stalled, so in_stall follows
// out_stall only when the whole pipe is full. Synchronous active-low reset empties the
// pipe, clears the magnitude history and the dot, and loads register defaults.
`timescale 1ns / 1ps

module current_sample_deadband_average_alarm (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [csda_pkg::SAMPLE_BITS-1:0]   in_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [csda_pkg::MAG_W-1:0]         out_average_magnitude,
  output logic [csda_pkg::LVL_W-1:0]         out_alarm_level,
  output logic                               out_polarity_dot,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [csda_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [csda_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [csda_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready
);
  import csda_pkg::*;

  cfg_t cfg;

  csda_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Pipeline registers.
  logic                   s0_v_r;
  logic [SAMPLE_BITS-1:0] s0_sample_r;
  logic                   s1_v_r;
  logic [SUM_W-1:0]       s1_sum_r;
  logic                   s1_dot_r;
  logic                   out_v_r;
  logic [MAG_W-1:0]       out_avg_r;
  logic [LVL_W-1:0]       out_lvl_r;
  logic                   out_dot_r;

  logic [MAG_W-1:0]       hist_r [HIST_DEPTH];
  logic                   dot_r;

  logic out_free, s1_free, s0_free;
  logic s0_move, s1_move;

  assign out_free = !out_v_r || !out_stall;
  assign s1_free  = !s1_v_r || out_free;
  assign s0_free  = !s0_v_r || s1_free;
  assign s0_move  = s0_v_r && s1_free;
  assign s1_move  = s1_v_r && out_free;
  assign in_stall = !s0_free;

  // Magnitude stage.
  logic [CMP_W-1:0]  s_ext, zp_ext, db_ext, lo_edge, hi_edge;
  logic              below, above;
  logic [DIST_W-1:0] distance;
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  mag_nxt;
  logic [SUM_W-1:0]  sum_nxt;
  logic              dot_nxt;

  always_comb begin
    s_ext    = CMP_W'(s0_sample_r);
    zp_ext   = CMP_W'(cfg.zero_point);
    db_ext   = CMP_W'(cfg.dead_band);
    lo_edge  = zp_ext - db_ext;     // may go negative
    hi_edge  = zp_ext + db_ext;
    below    = $signed(s_ext) < $signed(lo_edge);
    above    = s_ext > hi_edge;
    distance = below ? DIST_W'(zp_ext - s_ext) : DIST_W'(s_ext - zp_ext);
    prod     = {distance, 3'b000} - PROD_W'(distance);
    if (!below && !above) begin
      mag_nxt = '0;
    end else if (prod > PROD_W'(MAG_MAX)) begin
      mag_nxt = MAG_MAX;
    end else begin
      mag_nxt = MAG_W'(prod);
    end
    if (below) begin
      dot_nxt = !dot_r;
    end else if (above) begin
      dot_nxt = 1'b1;
    end else begin
      dot_nxt = dot_r;
    end
    sum_nxt = SUM_W'(mag_nxt) + SUM_W'(hist_r[0]) + SUM_W'(hist_r[1]);
  end

  // Average and alarm stage.
  logic [DIV3_W-1:0] quot_prod;
  logic [MAG_W-1:0]  avg_nxt;
  logic [LVL_W-1:0]  lvl_nxt;

  always_comb begin
    quot_prod = DIV3_W'(s1_sum_r) * DIV3_MUL;
    avg_nxt   = MAG_W'(quot_prod[DIV3_W-1:DIV3_SHIFT]);
    if (avg_nxt > cfg.low_alarm_limit && avg_nxt <= cfg.mid_alarm_limit) begin
      lvl_nxt = LVL_LOW;
    end else if (avg_nxt > cfg.mid_alarm_limit && avg_nxt <= cfg.high_alarm_limit) begin
      lvl_nxt = LVL_MID;
    end else if (avg_nxt > cfg.high_alarm_limit) begin
      lvl_nxt = LVL_HIGH;
    end else begin
      lvl_nxt = LVL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      dot_r   <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      if (s0_free) begin
        s0_v_r <= in_valid;
      end
      if (s1_free) begin
        s1_v_r <= s0_v_r;
      end
      if (out_free) begin
        out_v_r <= s1_v_r;
      end
      // history and dot advance once per transaction, when it leaves stage 0
      if (s0_move) begin
        dot_r     <= dot_nxt;
        hist_r[0] <= mag_nxt;
        for (int i = 1; i < HIST_DEPTH; i++) begin
          hist_r[i] <= hist_r[i-1];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s0_free && in_valid) begin
      s0_sample_r <= in_sample;
    end
    if (s0_move) begin
      s1_sum_r <= sum_nxt;
      s1_dot_r <= dot_nxt;
    end
    if (s1_move) begin
      out_avg_r <= avg_nxt;
      out_lvl_r <= lvl_nxt;
      out_dot_r <= s1_dot_r;
    end
  end

  assign out_valid             = out_v_r;
  assign out_average_magnitude = out_avg_r;
  assign out_alarm_level       = out_lvl_r;
  assign out_polarity_dot      = out_dot_r;

endmodule

### dv/tb_current_sample_deadband_average_alarm.sv
// Self-checking testbench for the current sample dead band, average and alarm block.
`timescale 1ns / 1ps

module tb_current_sample_deadband_average_alarm;
  import csda_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int ITEMS_PER_CFG  = 185;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
  localparam int LIMIT_MAX      = (1 << LIM_W) - 1;

  typedef struct packed {
    logic [MAG_W-1:0] avg;
    logic [LVL_W-1:0] level;
    logic             dot;
  } alarm_reading_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] in_sample = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [MAG_W-1:0]       out_average_magnitude;
  logic [LVL_W-1:0]       out_alarm_level;
  logic                   out_polarity_dot;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr = '0;
  logic [CFG_DW-1:0]      cfg_pwdata = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  // Predictor state
  cfg_t             alarm_cfg;
  logic [MAG_W-1:0] mag_history [HIST_DEPTH];
  logic             dot_state;
  alarm_reading_t   pending_readings [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  current_sample_deadband_average_alarm u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_sample             (in_sample),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_average_magnitude (out_average_magnitude),
    .out_alarm_level       (out_alarm_level),
    .out_polarity_dot      (out_polarity_dot),
    .cfg_psel              (cfg_psel),
    .cfg_penable           (cfg_penable),
    .cfg_pwrite            (cfg_pwrite),
    .cfg_paddr             (cfg_paddr),
    .cfg_pwdata            (cfg_pwdata),
    .cfg_prdata            (cfg_prdata),
    .cfg_pready            (cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Dead band, scale and saturate, three-point average, then alarm classing.
  function automatic alarm_reading_t predict_alarm_reading(input logic [SAMPLE_BITS-1:0] s);
    int             sv;
    int             zp;
    int             db;
    int             mag;
    int             avg;
    alarm_reading_t r;
    sv = int'(s);
    zp = int'(alarm_cfg.zero_point);
    db = int'(alarm_cfg.dead_band);
    mag = 0;
    if (sv < zp - db) begin
      mag = (zp - sv) * 7;
      dot_state = ~dot_state;
    end else if (sv > zp + db) begin
      mag = (sv - zp) * 7;
      dot_state = 1'b1;
    end
    if (mag > int'(MAG_MAX)) mag = int'(MAG_MAX);
    mag_history[2] = mag_history[1];
    mag_history[1] = mag_history[0];
    mag_history[0] = MAG_W'(mag);
    avg = (int'(mag_history[0]) + int'(mag_history[1]) + int'(mag_history[2])) / 3;
    r.avg = MAG_W'(avg);
    // first test that holds wins, so unordered limits fall through
    if (avg > int'(alarm_cfg.low_alarm_limit) && avg <= int'(alarm_cfg.mid_alarm_limit))
      r.level = LVL_LOW;
    else if (avg > int'(alarm_cfg.mid_alarm_limit) && avg <= int'(alarm_cfg.high_alarm_limit))
      r.level = LVL_MID;
    else if (avg > int'(alarm_cfg.high_alarm_limit))
      r.level = LVL_HIGH;
    else
      r.level = LVL_NONE;
    r.dot = dot_state;
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    alarm_reading_t exp_r;
    alarm_reading_t got_r;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got_r.avg = out_average_magnitude;
      got_r.level = out_alarm_level;
      got_r.dot = out_polarity_dot;
      if (pending_readings.size() == 0) begin
        if (mismatch_count < 10)
          $display("ERROR: unexpected transaction avg=%0d level=%0d dot=%0b",
                   got_r.avg, got_r.level, got_r.dot);
        mismatch_count++;
      end else begin
        exp_r = pending_readings.pop_front();
        if (got_r.avg !== exp_r.avg || got_r.level !== exp_r.level ||
            got_r.dot !== exp_r.dot) begin
          if (mismatch_count < 10)
            $display("ERROR: mismatch exp avg=%0d level=%0d dot=%0b got avg=%0d level=%0d dot=%0b",
                     exp_r.avg, exp_r.level, exp_r.dot, got_r.avg, got_r.level, got_r.dot);
          mismatch_count++;
        end
      end
    end
  end

  task automatic drive_sample(input int s);
    logic [SAMPLE_BITS-1:0] v;
    v = SAMPLE_BITS'(s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_readings.push_back(predict_alarm_reading(v));
  endtask

  // Drop valid and let the pipe drain before touching registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'({idx, 2'b00});
    cfg_pwdata <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_ZERO_POINT: alarm_cfg.zero_point = ZP_W'(value);
      REG_DEAD_BAND:  alarm_cfg.dead_band = DB_W'(value);
      REG_LOW_LIMIT:  alarm_cfg.low_alarm_limit = LIM_W'(value);
      REG_MID_LIMIT:  alarm_cfg.mid_alarm_limit = LIM_W'(value);
      REG_HIGH_LIMIT: alarm_cfg.high_alarm_limit = LIM_W'(value);
      default: ;
    endcase
  endtask

  task automatic configure(input int zp, input int db, input int lo, input int mid,
                           input int hi);
    wait_idle();
    write_reg(REG_ZERO_POINT, zp);
    write_reg(REG_DEAD_BAND, db);
    write_reg(REG_LOW_LIMIT, lo);
    write_reg(REG_MID_LIMIT, mid);
    write_reg(REG_HIGH_LIMIT, hi);
  endtask

  function automatic int pick_limit();
    case ($urandom_range(9))
      0: return 0;
      1: return LIMIT_MAX;
      default: return $urandom_range(4000);
    endcase
  endfunction

  task automatic random_config();
    int zp;
    int db;
    int lim [3];
    int t;
    case ($urandom_range(5))
      0: zp = 0;
      1: zp = SAMPLE_MAX;
      2: zp = $urandom_range(SAMPLE_MAX);
      default: zp = $urandom_range(700, 300);
    endcase
    case ($urandom_range(4))
      0: db = 0;
      1: db = (1 << DB_W) - 1;
      default: db = $urandom_range((1 << DB_W) - 1);
    endcase
    foreach (lim[i]) lim[i] = pick_limit();
    // mostly ordered limits, sometimes left unordered
    if ($urandom_range(3) != 0) begin
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2 - i; j++)
          if (lim[j] > lim[j+1]) begin
            t = lim[j];
            lim[j] = lim[j+1];
            lim[j+1] = t;
          end
    end
    configure(zp, db, lim[0], lim[1], lim[2]);
  endtask

  function automatic int pick_sample();
    int zp;
    int db;
    int s;
    zp = int'(alarm_cfg.zero_point);
    db = int'(alarm_cfg.dead_band);
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6: s = $urandom_range(SAMPLE_MAX);
      7, 8, 9, 10: s = zp - db + $urandom_range(2) - 1;
      11, 12, 13, 14: s = zp + db + $urandom_range(2) - 1;
      15: s = zp + $urandom_range(2 * db + 2) - db - 1;
      16, 17: s = ($urandom_range(1) != 0) ? SAMPLE_MAX : 0;
      default: s = zp + $urandom_range(300) - 150;
    endcase
    if (s < 0) s = 0;
    if (s > SAMPLE_MAX) s = SAMPLE_MAX;
    return s;
  endfunction

  // Reset defaults: band edges around 512, toggle and set of the dot, top level.
  task automatic test_default_band();
    drive_sample(506);
    drive_sample(507);
    drive_sample(517);
    drive_sample(518);
    drive_sample(0);
    drive_sample(SAMPLE_MAX);
    drive_sample(SAMPLE_MAX);
    drive_sample(SAMPLE_MAX);
  endtask

  // Band reaching below zero can never toggle; widest distance at both ends.
  task automatic test_band_extremes();
    configure(0, (1 << DB_W) - 1, 0, 0, 0);
    drive_sample(0);
    drive_sample(63);
    drive_sample(64);
    drive_sample(SAMPLE_MAX);
    configure(SAMPLE_MAX, 0, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX);
    drive_sample(SAMPLE_MAX);
    drive_sample(SAMPLE_MAX - 1);
    drive_sample(0);
    drive_sample(0);
    drive_sample(0);
  endtask

  // Limits out of order: classing falls through in fixed test order.
  task automatic test_unordered_limits();
    configure(512, 5, 5000, 100, 3000);
    drive_sample(0);
    drive_sample(0);
    drive_sample(512);
    drive_sample(600);
    configure(512, 5, 3000, 2000, 100);
    drive_sample(0);
    drive_sample(1000);
    drive_sample(512);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stl_pct);
    send_idle_pct = idle_pct;
    stall_pct = stl_pct;
    repeat (2) begin
      random_config();
      repeat (ITEMS_PER_CFG) drive_sample(pick_sample());
    end
  endtask

  initial begin
    alarm_cfg.zero_point = ZP_RST;
    alarm_cfg.dead_band = DB_RST;
    alarm_cfg.low_alarm_limit = LOW_RST;
    alarm_cfg.mid_alarm_limit = MID_RST;
    alarm_cfg.high_alarm_limit = HIGH_RST;
    foreach (mag_history[i]) mag_history[i] = '0;
    dot_state = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_band();
    test_band_extremes();
    test_unordered_limits();
    test_random_phase(0, 0);
    test_random_phase(63, 0);
    test_random_phase(0, 63);
    test_random_phase(10, 10);

    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
